[rtl/sact_pkg.sv]
package sact_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 5;
   localparam int OUT_SET_W  = 8;
   localparam int OUT_WAY_W  = 4;
   localparam int CNT_W      = 32;

   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_BITS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SET_BITS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WAYS_IN_USE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_POLICY      = 3'd3;

   localparam logic [3:0] RST_OFFSET_BITS = 4'd5;
   localparam logic [3:0] RST_SET_BITS    = 4'd0;
   localparam logic [4:0] RST_WAYS_IN_USE = 5'd1;

   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   typedef struct packed {
      logic load;
      logic commit;
   } cmd_type;

endpackage

[rtl/set_assoc_cache_tag_model.sv]
// Set-associative cache tag model, FIFO or LRU replacement.
// req channel: one address beat per access (req_valid/req_ready).
// rsp channel: one beat per access with hit, set, way, eviction flag and
//   saturating hit and access counters (rsp_valid/rsp_ready).
// csr channel: register writes (csr_index, csr_data), always ready; write
//   only while no access is outstanding.
// The set row is read from the tag and state memories at the request
//   edge; compare, victim select, row write-back and the result register
//   load follow at the commit edge, which waits while an earlier result
//   beat is stalled. A new request is taken only after the previous access
//   has committed, as req_ready is low in the lookup state.
// A stalled result holds its output register; one more request is taken
//   and waits in the lookup stage until the stalled beat is taken.
// Reset (synchronous): registers return to their defaults, counters clear,
//   and every set reads as empty at once; no clearing pass.
module set_assoc_cache_tag_model #(
   parameter int MAX_SET_BITS = 8,
   parameter int MAX_WAYS     = 16,
   parameter int ADDR_BITS    = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ADDR_BITS-1:0]            req_address,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_hit,
   output logic [sact_pkg::OUT_SET_W-1:0]  rsp_set_index,
   output logic [sact_pkg::OUT_WAY_W-1:0]  rsp_way,
   output logic                            rsp_evicted,
   output logic [sact_pkg::CNT_W-1:0]      rsp_hit_count,
   output logic [sact_pkg::CNT_W-1:0]      rsp_access_count,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sact_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sact_pkg::CSR_DATA_W-1:0] csr_data
);

   sact_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   sact_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sact_datapath #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_BITS    (ADDR_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_address      (req_address),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_hit          (rsp_hit),
      .rsp_set_index    (rsp_set_index),
      .rsp_way          (rsp_way),
      .rsp_evicted      (rsp_evicted),
      .rsp_hit_count    (rsp_hit_count),
      .rsp_access_count (rsp_access_count)
   );

endmodule

[rtl/sact_ctrl.sv]
module sact_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sact_pkg::cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LOOK = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.commit = (state_ff == ST_LOOK) && (!rsp_valid_ff || rsp_ready);
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_LOOK;
         ST_LOOK: if (cmd.commit) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/sact_datapath.sv]
module sact_datapath #(
   parameter int MAX_SET_BITS = 8,
   parameter int MAX_WAYS     = 16,
   parameter int ADDR_BITS    = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sact_pkg::cmd_type               cmd,
   input  logic [ADDR_BITS-1:0]            req_address,
   input  logic                            csr_write,
   input  logic [sact_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sact_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                            rsp_hit,
   output logic [sact_pkg::OUT_SET_W-1:0]  rsp_set_index,
   output logic [sact_pkg::OUT_WAY_W-1:0]  rsp_way,
   output logic                            rsp_evicted,
   output logic [sact_pkg::CNT_W-1:0]      rsp_hit_count,
   output logic [sact_pkg::CNT_W-1:0]      rsp_access_count
);

   localparam int SETS     = 1 << MAX_SET_BITS;
   localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_W   = WAY_W;
   localparam int NW_W     = $clog2(MAX_WAYS + 1) > 0 ? $clog2(MAX_WAYS + 1) : 1;
   localparam int RANK_MAX = MAX_WAYS - 1;
   localparam int CW       = sact_pkg::CNT_W;

   logic [3:0] offset_ff, setb_ff;
   logic [4:0] ways_ff;
   logic       policy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= sact_pkg::RST_OFFSET_BITS;
         setb_ff   <= sact_pkg::RST_SET_BITS;
         ways_ff   <= sact_pkg::RST_WAYS_IN_USE;
         policy_ff <= sact_pkg::POLICY_FIFO;
      end else if (csr_write) begin
         unique case (csr_index)
            sact_pkg::REG_OFFSET_BITS: offset_ff <= csr_data[3:0];
            sact_pkg::REG_SET_BITS:    setb_ff   <= csr_data[3:0];
            sact_pkg::REG_WAYS_IN_USE: ways_ff   <= csr_data[4:0];
            sact_pkg::REG_POLICY:      policy_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // address split
   logic [3:0]           sb;
   logic [ADDR_BITS-1:0] shifted, tag_rq;
   logic [SET_W:0]       one_sh;
   logic [SET_W-1:0]     set_mask, set_rq;

   always_comb begin
      sb       = (int'(setb_ff) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : setb_ff;
      shifted  = req_address >> offset_ff;
      one_sh   = (SET_W + 1)'(1) << sb;
      set_mask = SET_W'(one_sh - (SET_W + 1)'(1));
      set_rq   = shifted[SET_W-1:0] & set_mask;
      tag_rq   = shifted >> sb;
   end

   // stores
   logic [ADDR_BITS-1:0] tag_mem  [SETS][MAX_WAYS];
   logic [MAX_WAYS-1:0]  valid_mem[SETS];
   logic [RANK_W-1:0]    rank_mem [SETS][MAX_WAYS];
   logic [WAY_W-1:0]     fifo_mem [SETS];
   logic [SETS-1:0]      row_ok_ff;

   logic [SET_W-1:0]     set_ff;
   logic [ADDR_BITS-1:0] tag_ff;
   logic [ADDR_BITS-1:0] tag_row_ff  [MAX_WAYS];
   logic [MAX_WAYS-1:0]  valid_row_ff;
   logic [RANK_W-1:0]    rank_row_ff [MAX_WAYS];
   logic [WAY_W-1:0]     fifo_row_ff;
   logic                 row_ok_rd_ff;

   logic [MAX_WAYS-1:0]  valid_new;
   logic [RANK_W-1:0]    rank_new [MAX_WAYS];
   logic [WAY_W-1:0]     fifo_new;
   logic [WAY_W-1:0]     way_sel;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         set_ff       <= set_rq;
         tag_ff       <= tag_rq;
         tag_row_ff   <= tag_mem[set_rq];
         valid_row_ff <= valid_mem[set_rq];
         rank_row_ff  <= rank_mem[set_rq];
         fifo_row_ff  <= fifo_mem[set_rq];
         row_ok_rd_ff <= row_ok_ff[set_rq];
      end
      if (cmd.commit) begin
         tag_mem[set_ff][way_sel] <= tag_ff;
         valid_mem[set_ff]        <= valid_new;
         rank_mem[set_ff]         <= rank_new;
         fifo_mem[set_ff]         <= fifo_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ok_ff <= '0;
      end else if (cmd.commit) begin
         row_ok_ff[set_ff] <= 1'b1;
      end
   end

   // lookup and replacement
   logic [NW_W-1:0]     nways, fp_nx;
   logic [MAX_WAYS-1:0] in_use, valid_eff, hitv, emptyv, winv;
   logic [RANK_W-1:0]   rank_eff [MAX_WAYS];
   logic [WAY_W-1:0]    fifo_eff, fp, hit_w, empty_w, lru_w;
   logic                found, empty, evict;
   logic [RANK_W:0]     old_rank;

   always_comb begin
      if (ways_ff == 5'd0) begin
         nways = NW_W'(1);
      end else if (int'(ways_ff) > MAX_WAYS) begin
         nways = NW_W'(MAX_WAYS);
      end else begin
         nways = NW_W'(ways_ff);
      end
      valid_eff = row_ok_rd_ff ? valid_row_ff : '0;
      fifo_eff  = row_ok_rd_ff ? fifo_row_ff : '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         rank_eff[i] = row_ok_rd_ff ? rank_row_ff[i] : '0;
         in_use[i]   = NW_W'(i) < nways;
         hitv[i]     = valid_eff[i] && in_use[i] && (tag_row_ff[i] == tag_ff);
         emptyv[i]   = !valid_eff[i] && in_use[i];
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
         winv[i] = in_use[i];
         for (int j = 0; j < MAX_WAYS; j++) begin
            if (in_use[j] && j < i && rank_eff[j] >= rank_eff[i]) winv[i] = 1'b0;
            if (in_use[j] && j > i && rank_eff[j] > rank_eff[i]) winv[i] = 1'b0;
         end
      end
      hit_w   = '0;
      empty_w = '0;
      lru_w   = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (hitv[i])   hit_w   = WAY_W'(i);
         if (emptyv[i]) empty_w = WAY_W'(i);
         if (winv[i])   lru_w   = WAY_W'(i);
      end
      found = |hitv;
      empty = |emptyv;
      evict = !found && !empty;

      fp    = (NW_W'(fifo_eff) < nways) ? fifo_eff : '0;
      fp_nx = NW_W'(fp) + NW_W'(1);
      if (fp_nx == nways) fp_nx = '0;
      fifo_new = fifo_eff;
      if (evict && policy_ff == sact_pkg::POLICY_FIFO) fifo_new = WAY_W'(fp_nx);

      if (found) begin
         way_sel = hit_w;
      end else if (empty) begin
         way_sel = empty_w;
      end else if (policy_ff == sact_pkg::POLICY_LRU) begin
         way_sel = lru_w;
      end else begin
         way_sel = fp;
      end

      old_rank = found ? {1'b0, rank_eff[way_sel]} : (RANK_W + 1)'(MAX_WAYS);
      valid_new = valid_eff;
      valid_new[way_sel] = 1'b1;
      for (int i = 0; i < MAX_WAYS; i++) begin
         rank_new[i] = rank_eff[i];
         if (in_use[i] && WAY_W'(i) != way_sel && valid_eff[i]
             && {1'b0, rank_eff[i]} < old_rank
             && rank_eff[i] < RANK_W'(RANK_MAX)) begin
            rank_new[i] = rank_eff[i] + RANK_W'(1);
         end
      end
      rank_new[way_sel] = '0;
   end

   // counters and result beat
   logic [CW-1:0] hits_ff, acc_ff, hits_in, acc_in;
   logic [SET_W+sact_pkg::OUT_SET_W-1:0] set_ext;
   logic [WAY_W+sact_pkg::OUT_WAY_W-1:0] way_ext;

   always_comb begin
      hits_in = hits_ff;
      acc_in  = acc_ff;
      if (found && hits_ff != '1) hits_in = hits_ff + CW'(1);
      if (acc_ff != '1) acc_in = acc_ff + CW'(1);
      set_ext = {{sact_pkg::OUT_SET_W{1'b0}}, set_ff};
      way_ext = {{sact_pkg::OUT_WAY_W{1'b0}}, way_sel};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff <= '0;
         acc_ff  <= '0;
      end else if (cmd.commit) begin
         hits_ff <= hits_in;
         acc_ff  <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit          <= found;
         rsp_set_index    <= set_ext[sact_pkg::OUT_SET_W-1:0];
         rsp_way          <= way_ext[sact_pkg::OUT_WAY_W-1:0];
         rsp_evicted      <= evict;
         rsp_hit_count    <= hits_in;
         rsp_access_count <= acc_in;
      end
   end

endmodule

[rtl/sact_checker.sv]
module sact_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic        rsp_evicted,
   input logic [31:0] rsp_hit_count,
   input logic [31:0] rsp_access_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit_count)
         && $stable(rsp_access_count))
      else $error("stalled result beat changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while lookup in progress");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted))
      else $error("hit reported with eviction");

   a_counts_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_count <= rsp_access_count && rsp_access_count != 32'd0)
      else $error("hit count exceeds access count");

endmodule

bind set_assoc_cache_tag_model sact_checker u_sact_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_hit          (rsp_hit),
   .rsp_evicted      (rsp_evicted),
   .rsp_hit_count    (rsp_hit_count),
   .rsp_access_count (rsp_access_count)
);

[tb/tb_set_assoc_cache_tag_model.sv]
module tb_set_assoc_cache_tag_model;

   localparam int NSETS = 256;
   localparam int NWAYS = 16;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic        hit;
      logic [7:0]  set_index;
      logic [3:0]  way;
      logic        evicted;
      logic [31:0] hit_count;
      logic [31:0] access_count;
   } lookup_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic [31:0] req_address = '0;
   logic rsp_ready = 0;
   logic csr_valid = 0;
   logic [sact_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sact_pkg::CSR_DATA_W-1:0] csr_data = '0;
   logic req_ready, rsp_valid, rsp_hit, rsp_evicted, csr_ready;
   logic [sact_pkg::OUT_SET_W-1:0] rsp_set_index;
   logic [sact_pkg::OUT_WAY_W-1:0] rsp_way;
   logic [sact_pkg::CNT_W-1:0] rsp_hit_count, rsp_access_count;

   set_assoc_cache_tag_model DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_address(req_address),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .rsp_set_index(rsp_set_index), .rsp_way(rsp_way), .rsp_evicted(rsp_evicted),
      .rsp_hit_count(rsp_hit_count), .rsp_access_count(rsp_access_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // predictor state
   logic [31:0] tags [NSETS][NWAYS];
   logic        valid_line [NSETS][NWAYS];
   logic [3:0]  rank [NSETS][NWAYS];
   logic [3:0]  fifo_ptr [NSETS];
   logic [31:0] hits_seen = 0, accesses_seen = 0;
   logic [3:0]  cfg_offset = sact_pkg::RST_OFFSET_BITS;
   logic [3:0]  cfg_sets = sact_pkg::RST_SET_BITS;
   logic [4:0]  cfg_ways = sact_pkg::RST_WAYS_IN_USE;
   logic        cfg_policy = sact_pkg::POLICY_FIFO;

   logic [31:0] pending_addr [$];
   lookup_type  expected_lookups [$];
   logic [31:0] recent_addr [$];
   bit   req_taken = 0;
   bit   calm = 0;
   int   cycles = 0, fails = 0, checked = 0, evictions = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic age_lines(input int s, input int w, input int nw, input int old_rank);
      for (int i = 0; i < nw; i++)
         if (i != w && valid_line[s][i] && rank[s][i] < old_rank && rank[s][i] < NWAYS - 1)
            rank[s][i]++;
      rank[s][w] = 0;
   endtask

   task automatic cache_lookup(input logic [31:0] a, output lookup_type r);
      int sb, nw, s, w, best;
      logic [31:0] tag;
      bit found, empty;
      sb = cfg_sets > 8 ? 8 : int'(cfg_sets);
      nw = cfg_ways == 0 ? 1 : (cfg_ways > NWAYS ? NWAYS : int'(cfg_ways));
      s = int'((a >> cfg_offset) & ((32'd1 << sb) - 1));
      tag = (a >> cfg_offset) >> sb;
      found = 0;
      empty = 0;
      w = 0;
      r.evicted = 0;
      for (int i = 0; i < nw; i++)
         if (!found && valid_line[s][i] && tags[s][i] == tag) begin
            w = i;
            found = 1;
         end
      if (found) begin
         age_lines(s, w, nw, int'(rank[s][w]));
      end else begin
         for (int i = 0; i < nw; i++)
            if (!empty && !valid_line[s][i]) begin
               w = i;
               empty = 1;
            end
         if (!empty) begin
            r.evicted = 1;
            evictions++;
            if (cfg_policy == sact_pkg::POLICY_FIFO) begin
               w = fifo_ptr[s] < nw ? int'(fifo_ptr[s]) : 0;
               fifo_ptr[s] = 4'((w + 1) % nw);
            end else begin
               best = 0;
               w = 0;
               for (int i = 0; i < nw; i++)
                  if (rank[s][i] > best) begin
                     best = int'(rank[s][i]);
                     w = i;
                  end
            end
         end
         tags[s][w] = tag;
         valid_line[s][w] = 1;
         age_lines(s, w, nw, NWAYS);
      end
      if (found && hits_seen != 32'hFFFF_FFFF) hits_seen++;
      if (accesses_seen != 32'hFFFF_FFFF) accesses_seen++;
      r.hit = found;
      r.set_index = 8'(s);
      r.way = 4'(w);
      r.hit_count = hits_seen;
      r.access_count = accesses_seen;
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_addr.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
               req_valid <= 1;
               req_address <= pending_addr[0];
            end else begin
               req_valid <= 0;
            end
         end
         rsp_ready <= calm || $urandom_range(99) >= 22;
      end
   end

   // monitor
   always @(posedge clock) begin
      lookup_type r, e;
      req_taken = 0;
      if (!reset) begin
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("tb_set_assoc_cache_tag_model NOT OK");
            $finish;
         end else begin
            if (req_valid && req_ready) begin
               req_taken = 1;
               cache_lookup(pending_addr.pop_front(), r);
               expected_lookups.insert(expected_lookups.size(), r);
            end
            if (rsp_valid && rsp_ready) begin
               if (expected_lookups.size() == 0) begin
                  $error("rsp beat with no access outstanding");
                  fails++;
               end else begin
                  e = expected_lookups.pop_front();
                  checked++;
                  if (rsp_hit !== e.hit) begin
                     $error("hit exp %0d got %0d", e.hit, rsp_hit); fails++;
                  end
                  if (rsp_set_index !== e.set_index) begin
                     $error("set_index exp %0d got %0d", e.set_index, rsp_set_index); fails++;
                  end
                  if (rsp_way !== e.way) begin
                     $error("way exp %0d got %0d", e.way, rsp_way); fails++;
                  end
                  if (rsp_evicted !== e.evicted) begin
                     $error("evicted exp %0d got %0d", e.evicted, rsp_evicted); fails++;
                  end
                  if (rsp_hit_count !== e.hit_count) begin
                     $error("hit_count exp %0d got %0d", e.hit_count, rsp_hit_count);
                     fails++;
                  end
                  if (rsp_access_count !== e.access_count) begin
                     $error("access_count exp %0d got %0d", e.access_count,
                            rsp_access_count);
                     fails++;
                  end
               end
            end
         end
      end
   end

   task automatic csr_write(input logic [sact_pkg::CSR_IDX_W-1:0] idx, input logic [4:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         sact_pkg::REG_OFFSET_BITS: cfg_offset = val[3:0];
         sact_pkg::REG_SET_BITS:    cfg_sets = val[3:0];
         sact_pkg::REG_WAYS_IN_USE: cfg_ways = val;
         sact_pkg::REG_POLICY:      cfg_policy = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic drain();
      while (pending_addr.size() > 0 || expected_lookups.size() > 0 || req_valid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_address();
      int sh, nw;
      logic [31:0] a;
      nw = cfg_ways == 0 ? 1 : (cfg_ways > NWAYS ? NWAYS : int'(cfg_ways));
      sh = int'(cfg_offset) + (cfg_sets > 8 ? 8 : int'(cfg_sets));
      if ($urandom_range(99) < 10) begin
         a = $urandom;
      end else if ($urandom_range(99) < 45 && recent_addr.size() > 0) begin
         a = recent_addr[$urandom_range(recent_addr.size() - 1)];
         a = a ^ ($urandom & ((32'd1 << cfg_offset) - 1));
      end else begin
         a = ($urandom_range(nw + 3) << sh) ^ ($urandom & ((32'd1 << sh) - 1));
         if ($urandom_range(9) == 0) a[31:28] = 4'($urandom);
      end
      recent_addr.insert(recent_addr.size(), a);
      if (recent_addr.size() > 48) void'(recent_addr.pop_front());
      return a;
   endfunction

   initial begin
      int off_tab [10] = '{5, 0, 12, 15, 3, 0, 4, 2, 6, 1};
      int set_tab [10] = '{0, 8, 8, 15, 2, 0, 3, 1, 4, 5};
      int way_tab [10] = '{1, 16, 4, 0, 31, 16, 3, 2, 8, 5};
      int pol_tab [10] = '{0, 1, 0, 0, 1, 0, 1, 0, 1, 0};
      for (int s = 0; s < NSETS; s++) begin
         fifo_ptr[s] = 0;
         for (int w = 0; w < NWAYS; w++) begin
            valid_line[s][w] = 0;
            rank[s][w] = 0;
            tags[s][w] = 0;
         end
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // defaults from reset: direct mapped, one set
      pending_addr = '{32'h0, 32'h1F, 32'h20, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFE0,
                       32'h8000_0000, 32'h0};
      drain();
      for (int p = 1; p < 10; p++) begin
         csr_write(sact_pkg::REG_OFFSET_BITS, 5'(off_tab[p]));
         csr_write(sact_pkg::REG_SET_BITS, 5'(set_tab[p]));
         csr_write(sact_pkg::REG_WAYS_IN_USE, 5'(way_tab[p]));
         csr_write(sact_pkg::REG_POLICY, 5'(pol_tab[p]));
         calm = (p == 8);
         if (p == 1) begin
            // fill all ways of set 0, overflow, then revisit
            for (int t = 0; t <= 16; t++)
               pending_addr.insert(pending_addr.size(), 32'(t << 8));
            pending_addr.insert(pending_addr.size(), 32'h0);
            pending_addr.insert(pending_addr.size(), 32'h100);
         end
         for (int k = 0; k < 200; k++)
            pending_addr.insert(pending_addr.size(), pick_address());
         drain();
      end
      calm = 0;
      $display("checked %0d accesses: %0d hits, %0d evictions over 10 geometries",
               checked, hits_seen, evictions);
      if (fails == 0)
         $display("tb_set_assoc_cache_tag_model OK");
      else
         $display("tb_set_assoc_cache_tag_model NOT OK");
      $finish;
   end
endmodule

[sim.f]
rtl/sact_pkg.sv
rtl/sact_ctrl.sv
rtl/sact_datapath.sv
rtl/set_assoc_cache_tag_model.sv
rtl/sact_checker.sv
tb/tb_set_assoc_cache_tag_model.sv
